### rtl/core/slcfr_pkg.sv
// ----------------------------------------------------------------------------
// Frame receiver package
// Item types, status codes, constants and the CRC-16 byte update.
// ----------------------------------------------------------------------------
package slcfr_pkg;

    localparam int STORE_BYTES_DEF = 32;

    localparam logic [7:0]  SYNC_RESET = 8'hAA;
    localparam logic [15:0] CRC_POLY   = 16'h1021;

    localparam logic FUNC_RX   = 1'b0;
    localparam logic FUNC_READ = 1'b1;

    typedef enum logic [2:0] {
        ST_TAKEN   = 3'd0,
        ST_DROPPED = 3'd1,
        ST_GOOD    = 3'd2,
        ST_CRC_BAD = 3'd3,
        ST_LEN_ERR = 3'd4
    } status_t;

    typedef struct packed {
        logic       func;
        logic [7:0] rx_byte;
        logic [4:0] read_index;
    } in_item_t;

    typedef struct packed {
        status_t    status;
        logic [5:0] frame_len;
        logic [7:0] read_data;
    } out_item_t;

    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

### rtl/core/sync_length_crc_frame_receiver.sv
// ----------------------------------------------------------------------------
// Sync/length/CRC frame receiver
// Top level: input stage, frame engine and output stage.
// ----------------------------------------------------------------------------
// Each item on the s_ channel either delivers one received byte or asks for
// one byte of the stored frame. Every item yields exactly one result item on
// the m_ channel with a status, the frame length of a good frame and the
// read data of a read.
// A frame is two sync bytes equal to the value last written on cfg_wdata, a
// length byte L and further bytes up to L+2 in total; the last two bytes are
// a CRC-16/XMODEM over the length byte and the payload, high byte first.
// A result is offered on m_valid once its item has passed the input register
// and then the result register. One item is accepted in every cycle while
// m_ready stays high; the per-byte CRC update and compare sit between the two
// registers. When the receiver stalls, the result register holds its item,
// the input register holds the next item if there is one, and s_ready is low
// while the input register is full.
// Reset clears the frame state, empties the store and sets the sync value
// to 0xAA.
// ----------------------------------------------------------------------------
module sync_length_crc_frame_receiver
    import slcfr_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_we,
    input  logic [7:0] cfg_wdata,
    input  logic       s_valid,
    output logic       s_ready,
    input  in_item_t   s_item,
    output logic       m_valid,
    input  logic       m_ready,
    output out_item_t  m_item
);

    logic      item_valid;
    logic      item_ready;
    in_item_t  item;
    out_item_t res;
    logic      fire;

    assign fire = item_valid && item_ready;

    slcfr_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item)
    );

    slcfr_engine u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .fire      (fire),
        .item      (item),
        .res       (res)
    );

    slcfr_out_stage u_out_stage (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (item_valid),
        .res_ready (item_ready),
        .res       (res),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item)
    );

endmodule

### rtl/core/slcfr_in_stage.sv
// ----------------------------------------------------------------------------
// Input stage
// Registers one incoming item and holds it until the engine takes it.
// ----------------------------------------------------------------------------
module slcfr_in_stage
    import slcfr_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  in_item_t s_item,
    output logic     item_valid,
    input  logic     item_ready,
    output in_item_t item
);

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;
    logic     s_fire;

    assign s_ready    = !valid_reg || item_ready;
    assign s_fire     = s_valid && s_ready;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb begin
        valid_next = valid_reg;
        if (s_fire) begin
            valid_next = 1'b1;
        end else if (item_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            item_reg <= s_item;
        end
    end

endmodule

### rtl/core/slcfr_engine.sv
// ----------------------------------------------------------------------------
// Frame engine
// Tracks sync, length and CRC of the frame and keeps the frame store.
// ----------------------------------------------------------------------------
module slcfr_engine
    import slcfr_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_we,
    input  logic [7:0] cfg_wdata,
    input  logic       fire,
    input  in_item_t   item,
    output out_item_t  res
);

    localparam int STORE_BYTES = STORE_BYTES_DEF;
    localparam int POS_W       = $clog2(STORE_BYTES);

    logic [7:0]             sync_reg;
    logic [POS_W-1:0]       pos_reg;
    logic [POS_W-1:0]       pos_next;
    logic [15:0]            crc_reg;
    logic [15:0]            crc_next;
    logic [7:0]             len_reg;
    logic [7:0]             len_next;
    logic [7:0]             prev_reg;
    logic [7:0]             store_data_reg [STORE_BYTES];
    logic [STORE_BYTES-1:0] store_vld_reg;
    logic                   drop;
    logic                   wr_en;
    logic [POS_W-1:0]       rd_idx;
    logic [5:0]             flen_full;

    assign rd_idx    = POS_W'(item.read_index);
    assign flen_full = len_reg[5:0] + 6'd2;

    always_comb begin
        res      = '0;
        res.status = ST_TAKEN;
        drop     = 1'b0;
        wr_en    = 1'b0;
        pos_next = pos_reg;
        crc_next = crc_reg;
        len_next = len_reg;
        if (item.func == FUNC_READ) begin
            if (32'(item.read_index) < STORE_BYTES && store_vld_reg[rd_idx]) begin
                res.read_data = store_data_reg[rd_idx];
            end
        end else if (32'(pos_reg) >= STORE_BYTES) begin
            res.status = ST_DROPPED;
            drop       = 1'b1;
        end else if (pos_reg < POS_W'(2)) begin
            if (item.rx_byte == sync_reg) begin
                wr_en    = 1'b1;
                pos_next = pos_reg + POS_W'(1);
            end else begin
                res.status = ST_DROPPED;
                drop       = 1'b1;
            end
        end else if (pos_reg == POS_W'(2)) begin
            wr_en = 1'b1;
            if (item.rx_byte < 8'd2 || 32'(item.rx_byte) > STORE_BYTES - 2) begin
                res.status = ST_LEN_ERR;
                drop       = 1'b1;
            end else begin
                crc_next = (item.rx_byte >= 8'd3) ? crc_feed(16'h0000, item.rx_byte) : 16'h0000;
                len_next = item.rx_byte;
                pos_next = POS_W'(3);
            end
        end else begin
            if (len_reg < 8'd2 || 32'(len_reg) > STORE_BYTES - 2
                    || 32'(pos_reg) > 32'(len_reg) + 1) begin
                res.status = ST_DROPPED;
                drop       = 1'b1;
            end else if (32'(pos_reg) < 32'(len_reg) + 1) begin
                wr_en    = 1'b1;
                pos_next = pos_reg + POS_W'(1);
                if (32'(pos_reg) + 1 <= 32'(len_reg)) begin
                    crc_next = crc_feed(crc_reg, item.rx_byte);
                end
            end else begin
                wr_en = 1'b1;
                if (prev_reg == crc_reg[15:8] && item.rx_byte == crc_reg[7:0]) begin
                    res.status    = ST_GOOD;
                    res.frame_len = flen_full;
                    pos_next      = '0;
                end else begin
                    res.status = ST_CRC_BAD;
                    drop       = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sync_reg      <= SYNC_RESET;
            pos_reg       <= '0;
            crc_reg       <= '0;
            len_reg       <= '0;
            store_vld_reg <= '0;
        end else begin
            if (cfg_we) begin
                sync_reg <= cfg_wdata;
            end
            if (fire) begin
                crc_reg <= crc_next;
                len_reg <= len_next;
                if (drop) begin
                    pos_reg       <= '0;
                    store_vld_reg <= '0;
                end else begin
                    pos_reg <= pos_next;
                    if (wr_en) begin
                        store_vld_reg[pos_reg] <= 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fire && wr_en) begin
            store_data_reg[pos_reg] <= item.rx_byte;
            prev_reg                <= item.rx_byte;
        end
    end

    a_pos_in_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg >= POS_W'(3) |-> 32'(pos_reg) <= 32'(len_reg) + 1)
        else $error("write position beyond the frame end");

    a_len_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg >= POS_W'(3) |-> len_reg >= 8'd2 && 32'(len_reg) <= STORE_BYTES - 2)
        else $error("frame in progress with an illegal length");

    a_drop_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && drop |=> store_vld_reg == '0 && pos_reg == '0)
        else $error("dropped frame left data in the store");

    a_good_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && res.status == ST_GOOD |=> pos_reg == '0 && store_vld_reg != '0)
        else $error("good frame did not restart reception");

endmodule

### rtl/core/slcfr_out_stage.sv
// ----------------------------------------------------------------------------
// Output stage
// Result register that holds a finished item until the receiver takes it.
// ----------------------------------------------------------------------------
module slcfr_out_stage
    import slcfr_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      res_valid,
    output logic      res_ready,
    input  out_item_t res,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_item
);

    logic      valid_reg;
    logic      valid_next;
    out_item_t item_reg;
    logic      load;

    assign res_ready = !valid_reg || m_ready;
    assign load      = res_valid && res_ready;
    assign m_valid   = valid_reg;
    assign m_item    = item_reg;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            item_reg <= res;
        end
    end

endmodule

### tb/slcfr_scoreboard.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame receiver scoreboard
// Watches the sync register port and both item channels. It keeps its own
// copy of the frame store, write position, running CRC-16 and sync value, and
// works out one result for every accepted input item. Results from the block
// are compared in order, field by field, against the oldest one still due.
// ----------------------------------------------------------------------------
module slcfr_scoreboard
    import slcfr_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      cfg_we,
    input  logic [7:0] cfg_wdata,
    input  logic      s_valid,
    input  logic      s_ready,
    input  in_item_t  s_item,
    input  logic      m_valid,
    input  logic      m_ready,
    input  out_item_t m_item,
    output int        mismatches,
    output int        pending_results
);

    localparam int MAX_LEN = STORE_BYTES_DEF - 2;

    logic [7:0]  sync_byte;
    logic [7:0]  frame_mem [STORE_BYTES_DEF];
    logic [5:0]  next_pos;
    logic [15:0] crc_acc;
    out_item_t   results_due [$];
    int          fail_tally = 0;

    function automatic logic [15:0] crc16_update(input logic [15:0] crc, input logic [7:0] data);
        logic [15:0] acc;
        logic        fb;
        int          k;
        acc = crc;
        for (k = 7; k >= 0; k--) begin
            fb  = acc[15] ^ data[k];
            acc = {acc[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
        end
        return acc;
    endfunction

    task automatic clear_frame();
        int k;
        for (k = 0; k < STORE_BYTES_DEF; k++) begin
            frame_mem[5'(k)] = 8'h00;
        end
        next_pos = 6'd0;
    endtask

    task automatic receiver_step(input in_item_t it, output out_item_t res);
        logic [7:0] len;
        res.status    = ST_TAKEN;
        res.frame_len = 6'd0;
        res.read_data = 8'h00;
        len = frame_mem[2];
        if (it.func == FUNC_READ) begin
            res.read_data = frame_mem[it.read_index];
        end else if (next_pos >= STORE_BYTES_DEF) begin
            res.status = ST_DROPPED;
            clear_frame();
        end else if (next_pos < 2) begin
            if (it.rx_byte == sync_byte) begin
                frame_mem[next_pos[4:0]] = it.rx_byte;
                next_pos = next_pos + 6'd1;
            end else begin
                res.status = ST_DROPPED;
                clear_frame();
            end
        end else if (next_pos == 2) begin
            frame_mem[2] = it.rx_byte;
            if (it.rx_byte < 2 || it.rx_byte > MAX_LEN) begin
                res.status = ST_LEN_ERR;
                clear_frame();
            end else begin
                crc_acc  = (it.rx_byte >= 3) ? crc16_update(16'h0000, it.rx_byte) : 16'h0000;
                next_pos = 6'd3;
            end
        end else if (len < 2 || len > MAX_LEN || next_pos > len + 1) begin
            res.status = ST_DROPPED;
            clear_frame();
        end else if (next_pos < len + 1) begin
            frame_mem[next_pos[4:0]] = it.rx_byte;
            if (next_pos < len) begin
                crc_acc = crc16_update(crc_acc, it.rx_byte);
            end
            next_pos = next_pos + 6'd1;
        end else begin
            frame_mem[next_pos[4:0]] = it.rx_byte;
            if (frame_mem[5'(next_pos - 6'd1)] == crc_acc[15:8] &&
                it.rx_byte == crc_acc[7:0]) begin
                res.status    = ST_GOOD;
                res.frame_len = 6'(len + 2);
                next_pos      = 6'd0;
            end else begin
                res.status = ST_CRC_BAD;
                clear_frame();
            end
        end
    endtask

    always @(posedge aclk) begin : watch
        out_item_t predicted;
        out_item_t due;
        if (!aresetn) begin
            sync_byte = SYNC_RESET;
            crc_acc   = 16'h0000;
            clear_frame();
            results_due.delete();
        end else begin
            if (s_valid && s_ready) begin
                receiver_step(s_item, predicted);
                results_due.push_back(predicted);
            end
            if (m_valid && m_ready) begin
                if (results_due.size() == 0) begin
                    fail_tally++;
                    $display("%0t: result with none due: expected none, %s",
                             $time, "got the following");
                    $display("    status %0d len %0d data 0x%02h",
                             m_item.status, m_item.frame_len, m_item.read_data);
                end else begin
                    due = results_due.pop_front();
                    if (m_item.status !== due.status || m_item.frame_len !== due.frame_len ||
                        m_item.read_data !== due.read_data) begin
                        fail_tally++;
                        $display("%0t: result mismatch: expected status %0d len %0d data 0x%02h,",
                                 $time, due.status, due.frame_len, due.read_data);
                        $display("    got status %0d len %0d data 0x%02h",
                                 m_item.status, m_item.frame_len, m_item.read_data);
                    end
                end
            end
            if (cfg_we) begin
                sync_byte = cfg_wdata;
            end
        end
        mismatches      <= fail_tally;
        pending_results <= results_due.size();
    end

endmodule

### tb/tb_sync_length_crc_frame_receiver.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame receiver regression bench
// Drives the receiver with framed byte streams, read items and noise under
// several sync values and flow-control patterns. A scoreboard module beside
// the block predicts and checks every result; this top only makes stimulus,
// watches for a hang and reports the verdict.
// ----------------------------------------------------------------------------
module tb_sync_length_crc_frame_receiver;
    import slcfr_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 300;
    localparam int TAIL_CYCLES    = 8;

    logic       aclk;
    logic       aresetn;
    logic       cfg_we;
    logic [7:0] cfg_wdata;
    logic       s_valid;
    logic       s_ready;
    in_item_t   s_item;
    logic       m_valid;
    logic       m_ready;
    out_item_t  m_item;

    int         mismatches;
    int         pending_results;
    int         send_idle_pct  = 0;
    int         recv_stall_pct = 0;
    int         read_mix_pct   = 0;
    bit         hold_request   = 1'b0;
    int         items_sent     = 0;
    int         intact_frames  = 0;
    int         flawed_frames  = 0;
    int         quiet_cycles   = 0;
    logic [7:0] cur_sync       = SYNC_RESET;

    sync_length_crc_frame_receiver dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item)
    );

    slcfr_scoreboard scoreboard (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_item          (s_item),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_item          (m_item),
        .mismatches      (mismatches),
        .pending_results (pending_results)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_request) begin
                hold_request = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge aclk);
            end else begin
                m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("sync_length_crc_frame_receiver regression: fail");
            $finish;
        end
    end

    function automatic logic [15:0] xmodem_next(input logic [15:0] crc, input logic [7:0] data);
        logic [15:0] acc;
        int          k;
        acc = crc ^ {data, 8'h00};
        for (k = 0; k < 8; k++) begin
            acc = acc[15] ? ({acc[14:0], 1'b0} ^ CRC_POLY) : {acc[14:0], 1'b0};
        end
        return acc;
    endfunction

    task automatic offer(input in_item_t it);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= it;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        items_sent++;
    endtask

    task automatic send_byte(input logic [7:0] b);
        in_item_t it;
        it.func       = FUNC_RX;
        it.rx_byte    = b;
        it.read_index = 5'($urandom_range(0, 31));
        offer(it);
    endtask

    task automatic send_read(input logic [4:0] idx);
        in_item_t it;
        it.func       = FUNC_READ;
        it.rx_byte    = 8'($urandom_range(0, 255));
        it.read_index = idx;
        offer(it);
    endtask

    // damage: 0 intact, 1 one random bit flipped anywhere, 2 low CRC byte wrong.
    task automatic send_frame(input int len, input int damage, input bit cut);
        logic [7:0]  bytes [32];
        logic [15:0] crc;
        int          n;
        int          k;
        n   = len + 2;
        crc = 16'h0000;
        bytes[0] = cur_sync;
        bytes[1] = cur_sync;
        bytes[2] = 8'(len);
        for (k = 3; k < len; k++) begin
            bytes[5'(k)] = 8'($urandom_range(0, 255));
        end
        for (k = 2; k < len; k++) begin
            crc = xmodem_next(crc, bytes[5'(k)]);
        end
        if (len > 2) begin
            bytes[5'(len)] = crc[15:8];
        end
        bytes[5'(len + 1)] = crc[7:0];
        if (damage == 1) begin
            k = $urandom_range(0, n - 1);
            bytes[5'(k)] = bytes[5'(k)] ^ (8'd1 << $urandom_range(0, 7));
        end else if (damage == 2) begin
            bytes[5'(len + 1)] = bytes[5'(len + 1)] ^ 8'h01;
        end
        if (cut) begin
            n = $urandom_range(1, n - 1);
        end
        for (k = 0; k < n; k++) begin
            if ($urandom_range(0, 99) < read_mix_pct) begin
                send_read(5'($urandom_range(0, 31)));
            end
            send_byte(bytes[5'(k)]);
        end
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_results != 0);
        @(negedge aclk);
    endtask

    task automatic write_sync(input logic [7:0] v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        cur_sync   = v;
        @(negedge aclk);
        cfg_we    <= 1'b0;
    endtask

    task automatic run_traffic(input int quota);
        int stop;
        int roll;
        int len;
        int k;
        stop = items_sent + quota;
        while (items_sent < stop) begin
            roll = $urandom_range(0, 99);
            len  = ($urandom_range(0, 1) == 0) ? $urandom_range(2, 8) : $urandom_range(2, 30);
            if (roll < 55) begin
                send_frame(len, 0, 1'b0);
                intact_frames++;
            end else if (roll < 68) begin
                send_frame(len, $urandom_range(1, 2), 1'b0);
                flawed_frames++;
            end else if (roll < 73) begin
                send_frame(len, 0, 1'b1);
                flawed_frames++;
            end else if (roll < 80) begin
                k = $urandom_range(0, 3);
                send_byte(cur_sync);
                send_byte(cur_sync);
                send_byte((k == 0) ? 8'd0 : (k == 1) ? 8'd1 : (k == 2) ? 8'd31 :
                          8'($urandom_range(32, 255)));
                flawed_frames++;
            end else if (roll < 92) begin
                repeat ($urandom_range(1, 4)) send_read(5'($urandom_range(0, 31)));
            end else begin
                repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)));
            end
        end
    endtask

    initial begin
        aresetn   = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = 8'h00;
        s_valid   = 1'b0;
        s_item    = '0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        send_read(5'd0);
        send_read(5'd31);
        send_byte(8'h00);
        send_frame(3, 0, 1'b0);
        send_read(5'd2);
        send_read(5'd4);
        send_byte(cur_sync);
        send_byte(cur_sync);
        send_byte(8'd2);
        send_byte(8'hFF);
        send_byte(cur_sync);
        send_byte(cur_sync);
        send_byte(8'd0);
        send_byte(cur_sync);
        send_byte(cur_sync);
        send_byte(8'hFF);
        send_frame(3, 2, 1'b0);
        drain();

        read_mix_pct = 10;
        write_sync(8'h00);
        run_traffic(250);
        drain();

        write_sync(8'hFF);
        send_idle_pct = 60;
        run_traffic(120);
        drain();
        run_traffic(130);
        drain();

        write_sync(8'($urandom_range(0, 255)));
        send_idle_pct  = 0;
        recv_stall_pct = 60;
        run_traffic(60);
        hold_request = 1'b1;
        run_traffic(190);
        drain();

        write_sync(8'hAA);
        send_idle_pct  = 19;
        recv_stall_pct = 19;
        run_traffic(250);
        drain();

        write_sync(8'($urandom_range(0, 255)));
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        run_traffic(250);
        drain();
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("Covered %0d input items in six phases with sync values %s.",
                 items_sent, "0x00, 0xFF, 0xAA and random ones");
        $display("Sent %0d intact frames and %0d damaged, cut or badly sized ones, %s.",
                 intact_frames, flawed_frames, "with reads mixed in");
        if (mismatches == 0 && pending_results == 0) begin
            $display("sync_length_crc_frame_receiver regression: pass");
        end else begin
            $display("sync_length_crc_frame_receiver regression: fail");
        end
        $finish;
    end

endmodule

### sim.f
rtl/core/slcfr_pkg.sv
rtl/core/slcfr_in_stage.sv
rtl/core/slcfr_engine.sv
rtl/core/slcfr_out_stage.sv
rtl/core/sync_length_crc_frame_receiver.sv
tb/slcfr_scoreboard.sv
tb/tb_sync_length_crc_frame_receiver.sv
